### src/rdst_pkg.sv
// ----------------------------------------------------------------------------
// rdst_pkg
// Types, constants and helper functions shared by the range digit sum unit.
// ----------------------------------------------------------------------------
package rdst_pkg;

  localparam int DIGITS  = 16;
  localparam int BOUND_W = 64;
  localparam int ACC_W   = 60;
  localparam int PRE_W   = 8;
  localparam int INNER_W = 12;
  localparam int IDX_W   = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int LATENCY = DIGITS + 2;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_ORDER = 2'd1,
    ERR_DIGIT = 2'd2
  } err_t;

  typedef struct packed {
    logic [BOUND_W-1:0] low_bound;
    logic [BOUND_W-1:0] high_bound;
  } in_t;

  typedef struct packed {
    logic [ACC_W-1:0] digit_sum_total;
    err_t             error_code;
  } out_t;

  typedef struct packed {
    logic [BOUND_W-1:0] lo_bound;
    logic [BOUND_W-1:0] hi_bound;
    logic [ACC_W-1:0]   acc_lo;
    logic [ACC_W-1:0]   acc_hi;
    logic [PRE_W-1:0]   pre_lo;
    logic [PRE_W-1:0]   pre_hi;
    err_t               err;
  } stage_t;

  // 10 to the power n, for n up to DIGITS
  function automatic logic [ACC_W-1:0] pow10(input int unsigned n);
    logic [ACC_W-1:0] p;
    p = ACC_W'(1);
    for (int k = 0; k < DIGITS; k++) begin
      if (k < n) p = ACC_W'(p * ACC_W'(10));
    end
    return p;
  endfunction

  // digit total of all n-digit tails: 45 * n * 10^(n-1)
  function automatic logic [ACC_W-1:0] tail_weight(input int unsigned n);
    logic [ACC_W-1:0] w;
    w = '0;
    if (n > 0) w = ACC_W'(ACC_W'(45 * n) * pow10(n - 1));
    return w;
  endfunction

  // d * (d - 1) / 2 for a decimal digit
  function automatic logic [INNER_W-1:0] tri_num(input logic [3:0] d);
    logic [INNER_W-1:0] t;
    case (d)
      4'd2:    t = INNER_W'(1);
      4'd3:    t = INNER_W'(3);
      4'd4:    t = INNER_W'(6);
      4'd5:    t = INNER_W'(10);
      4'd6:    t = INNER_W'(15);
      4'd7:    t = INNER_W'(21);
      4'd8:    t = INNER_W'(28);
      4'd9:    t = INNER_W'(36);
      default: t = '0;
    endcase
    return t;
  endfunction

  // mask of the used nibbles
  function automatic logic [BOUND_W-1:0] digit_mask();
    logic [BOUND_W-1:0] m;
    m = '0;
    for (int k = 0; k < DIGITS; k++) m[4*k +: 4] = 4'hf;
    return m;
  endfunction

endpackage

### src/rdst_check.sv
// ----------------------------------------------------------------------------
// rdst_check
// Entry stage: masks unused nibbles, checks digits and bound order.
// ----------------------------------------------------------------------------
module rdst_check (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  rdst_pkg::in_t  in_data,
  output logic           out_valid,
  output rdst_pkg::stage_t out_data
);
  import rdst_pkg::*;

  logic               valid_r;
  stage_t             data_r, data_nxt;
  logic [BOUND_W-1:0] lo_m, hi_m;
  logic               bad_digit;

  always_comb begin
    lo_m = in_data.low_bound & digit_mask();
    hi_m = in_data.high_bound & digit_mask();
    bad_digit = 1'b0;
    for (int k = 0; k < DIGITS; k++) begin
      if (lo_m[4*k +: 4] > 4'd9 || hi_m[4*k +: 4] > 4'd9) bad_digit = 1'b1;
    end
    data_nxt.lo_bound = lo_m;
    data_nxt.hi_bound = hi_m;
    data_nxt.acc_lo   = '0;
    data_nxt.acc_hi   = '0;
    data_nxt.pre_lo   = '0;
    data_nxt.pre_hi   = '0;
    // packed bcd orders like its binary pattern
    if (bad_digit)        data_nxt.err = ERR_DIGIT;
    else if (lo_m > hi_m) data_nxt.err = ERR_ORDER;
    else                  data_nxt.err = ERR_OK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

### src/rdst_digit_stage.sv
// ----------------------------------------------------------------------------
// rdst_digit_stage
// One digit position of the closed-form prefix total, for both bounds.
// ----------------------------------------------------------------------------
module rdst_digit_stage (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [rdst_pkg::IDX_W-1:0] digit_idx,
  input  logic                  in_valid,
  input  rdst_pkg::stage_t      in_data,
  output logic                  out_valid,
  output rdst_pkg::stage_t      out_data
);
  import rdst_pkg::*;

  logic               valid_r;
  stage_t             data_r, data_nxt;
  logic [ACC_W-1:0]   pw, tl;
  logic [3:0]         d_lo, d_hi;
  logic [INNER_W-1:0] inner_lo, inner_hi;

  assign pw = pow10(int'(digit_idx));
  assign tl = tail_weight(int'(digit_idx));

  always_comb begin
    d_lo = in_data.lo_bound[{digit_idx, 2'b00} +: 4];
    d_hi = in_data.hi_bound[{digit_idx, 2'b00} +: 4];
    inner_lo = INNER_W'(d_lo) * INNER_W'(in_data.pre_lo) + tri_num(d_lo);
    inner_hi = INNER_W'(d_hi) * INNER_W'(in_data.pre_hi) + tri_num(d_hi);
    data_nxt = in_data;
    // smaller digits here, each followed by every tail
    data_nxt.acc_lo = in_data.acc_lo + ACC_W'(pw * ACC_W'(inner_lo))
                      + ACC_W'(ACC_W'(d_lo) * tl);
    data_nxt.acc_hi = in_data.acc_hi + ACC_W'(pw * ACC_W'(inner_hi))
                      + ACC_W'(ACC_W'(d_hi) * tl);
    data_nxt.pre_lo = in_data.pre_lo + PRE_W'(d_lo);
    data_nxt.pre_hi = in_data.pre_hi + PRE_W'(d_hi);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

### src/rdst_finish.sv
// ----------------------------------------------------------------------------
// rdst_finish
// Output stage: combines both prefix totals and applies the error result.
// ----------------------------------------------------------------------------
module rdst_finish (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  rdst_pkg::stage_t in_data,
  output logic             out_valid,
  output rdst_pkg::out_t   out_data
);
  import rdst_pkg::*;

  logic valid_r;
  out_t data_r, data_nxt;

  always_comb begin
    data_nxt.error_code = in_data.err;
    // F(high) - F(low) + digit sum of high
    if (in_data.err == ERR_OK) begin
      data_nxt.digit_sum_total = in_data.acc_hi + ACC_W'(in_data.pre_hi) - in_data.acc_lo;
    end else begin
      data_nxt.digit_sum_total = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

### src/range_digit_sum_total_unit.sv
// ----------------------------------------------------------------------------
// range_digit_sum_total_unit
// Sum of decimal digit sums over an inclusive range of packed BCD bounds.
// ----------------------------------------------------------------------------
// A request is taken on every cycle in which start is high; busy stays low,
// since the pipeline never stalls. Each result appears on out_data for one
// cycle with out_valid high, after its request has passed one check stage,
// one stage per digit position from the most significant down, and one
// output stage. Results come out in request order and must be taken when
// shown. A bad digit gives error code 2 and a reversed range error code 1,
// both with a zero total.
module range_digit_sum_total_unit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  rdst_pkg::in_t  in_data,
  output logic           out_valid,
  output rdst_pkg::out_t out_data
);
  import rdst_pkg::*;

  logic   stg_valid [DIGITS+1];
  stage_t stg_data  [DIGITS+1];

  assign busy = 1'b0;

  rdst_check u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start),
    .in_data   (in_data),
    .out_valid (stg_valid[0]),
    .out_data  (stg_data[0])
  );

  for (genvar k = 0; k < DIGITS; k++) begin : g_digit
    rdst_digit_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .digit_idx (IDX_W'(DIGITS - 1 - k)),
      .in_valid  (stg_valid[k]),
      .in_data   (stg_data[k]),
      .out_valid (stg_valid[k+1]),
      .out_data  (stg_data[k+1])
    );
  end

  rdst_finish u_finish (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (stg_valid[DIGITS]),
    .in_data   (stg_data[DIGITS]),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

### src/rdst_checker.sv
// ----------------------------------------------------------------------------
// rdst_checker
// Port-level checks on the range digit sum unit, bound to the top level.
// ----------------------------------------------------------------------------
module rdst_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           start,
  input logic           busy,
  input rdst_pkg::in_t  in_data,
  input logic           out_valid,
  input rdst_pkg::out_t out_data
);
  import rdst_pkg::*;

  // every accepted beat comes out after the fixed latency
  a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(LATENCY) out_valid)
    else $error("accepted beat produced no result");

  // no result without a beat accepted that long ago
  a_latency_bwd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result without matching beat");

  // an error result carries a zero total
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.error_code != ERR_OK) |-> (out_data.digit_sum_total == '0))
    else $error("error result with nonzero total");

  // identical bounds give the digit sum of that bound, so a result of a
  // reversed range needs distinct bounds
  a_order_err: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.low_bound == in_data.high_bound)
      |-> ##(LATENCY) (out_data.error_code != ERR_ORDER))
    else $error("order error on equal bounds");

endmodule

bind range_digit_sum_total_unit rdst_checker u_rdst_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);
